// File: rtl/efa_pkg.sv
// ----------------------------------------------------------------------------
// efa_pkg
// Shared types, widths and constants of the event frame accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package efa_pkg;

   // default store geometry
   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   // field widths
   localparam int COUNT_BITS  = 16;
   localparam int POS_W       = 9;
   localparam int KIND_W      = 2;
   localparam int CHAN_W      = 16;
   localparam int SV_W        = 29;
   localparam int MODE_W      = 3;
   localparam int DIM_REG_W   = 10;
   localparam int DIM_W       = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 80;

   // register reset values
   localparam logic [DIM_REG_W-1:0] DIM_RESET = DIM_REG_W'(512);

   // renderer shades
   localparam logic [CHAN_W-1:0] SHADE_UNTOUCHED = CHAN_W'(230);
   localparam logic [CHAN_W-1:0] SHADE_FULL      = CHAN_W'(255);
   localparam logic [CHAN_W-1:0] SHADE_UNIT      = CHAN_W'(1);

   // grey value: 0.5 + 0.05*d in Q16, 16384*m/5 = 3276*m + (4*m)/5
   localparam logic [SV_W-1:0] GREY_HALF   = SV_W'(32768);
   localparam int              GREY_WHOLE  = 3276;
   localparam int              HI_W        = 28;
   localparam int              LO_A_W      = COUNT_BITS + 2;
   localparam int              RECIP_W     = 16;
   localparam logic [RECIP_W-1:0] RECIP_5  = RECIP_W'(52429);

   // request kinds carried in tuser
   typedef enum logic [KIND_W-1:0] {
      REQ_EVENT = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2
   } req_kind_type;

   // display modes
   typedef enum logic [MODE_W-1:0] {
      MODE_RENDER   = 3'd0,
      MODE_SIGNED   = 3'd1,
      MODE_COLOUR   = 3'd2,
      MODE_UNSIGNED = 3'd3,
      MODE_GREY     = 3'd4
   } mode_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE   = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   // input transfer payload, lowest field first from the bottom
   typedef struct packed {
      logic [3:0]       pad;
      logic             inside_req;
      logic             polarity;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_x;
   } req_data_type;

   // result transfer payload
   typedef struct packed {
      logic [2:0]        pad;
      logic [SV_W-1:0]   scalar_value;
      logic [CHAN_W-1:0] chan_r;
      logic [CHAN_W-1:0] chan_g;
      logic [CHAN_W-1:0] chan_b;
   } rsp_data_type;

   // one word of the pixel store
   typedef struct packed {
      logic                  touched;
      logic                  last_sign;
      logic [COUNT_BITS-1:0] neg_count;
      logic [COUNT_BITS-1:0] pos_count;
   } pixel_type;

endpackage

`default_nettype wire

// File: rtl/efa_ram.sv
// ----------------------------------------------------------------------------
// efa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module efa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/event_frame_accumulator.sv
// ----------------------------------------------------------------------------
// event_frame_accumulator
// Per-pixel event accumulation into one pixel store, with pixel reads
// rendered in the selected display mode and a full-store clear.
// ----------------------------------------------------------------------------
// sequence: an event reads the store, then writes the pixel back; a read
//    latches the pixel, then the grey products, then loads its result
//    register once that is free
// throughput: one item at a time, set by the single read-modify-write on
//    the pixel store; a dropped event or unknown request every cycle
// clear request and reset: a clearing pass writes one entry per cycle over
//    all MAX_WIDTH*MAX_HEIGHT entries (262144 by default), no request taken then
// ----------------------------------------------------------------------------
`default_nettype none

module event_frame_accumulator #(
   parameter int MAX_WIDTH  = efa_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = efa_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // pos_x[8:0], pos_y[17:9], polarity[18], inside_req[19], zero fill
   input  logic [efa_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [efa_pkg::KIND_W-1:0]     req_tuser,
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // chan_b[15:0], chan_g[31:16], chan_r[47:32], scalar_value[76:48], zero fill
   output logic [efa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration port
   input  logic                           csr_wr_en,
   input  logic [efa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [efa_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   import efa_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PIX_W  = $bits(pixel_type);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_READ  = 5'b00100,
      S_MUL   = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      cursor_ff, cursor_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MODE_W-1:0]      mode_ff;
   logic [DIM_REG_W-1:0]   width_ff, height_ff;

   // payload registers
   logic                   is_read_ff;
   logic                   pol_ff;
   logic                   ok_ff;
   logic [ADDR_W-1:0]      addr_ff;
   pixel_type              pix_ff, pix_in;
   logic signed [COUNT_BITS:0] diff_ff, diff_in;
   logic [COUNT_BITS-1:0]  mag_in, mag_ff;
   logic [HI_W-1:0]        hi_ff, hi_in;
   logic [COUNT_BITS-1:0]  lo_ff, lo_in;
   rsp_data_type           rsp_data_ff, rsp_data_in;

   // request decode
   req_data_type           req;
   req_kind_type           kind;
   logic                   accept;
   logic                   in_area;
   logic [ADDR_W-1:0]      req_addr;
   logic                   load_rsp;

   // store ports
   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   pixel_type              ram_wr_data;
   logic                   ram_rd_en;
   logic [PIX_W-1:0]       ram_rd_raw;
   pixel_type              ram_rd_data;

   // grey arithmetic
   logic [LO_A_W-1:0]         lo_a;
   logic [LO_A_W+RECIP_W-1:0] recip_prod;
   logic [HI_W-1:0]           grey_q;
   logic [SV_W-1:0]           grey_val;

   assign req    = req_data_type'(req_tdata);
   assign kind   = req_kind_type'(req_tuser);
   assign accept = req_tvalid && req_tready;

   // bounds test against both the register and the store geometry
   assign in_area = (DIM_W'(req.pos_x) < DIM_W'(width_ff))  &&
                    (DIM_W'(req.pos_x) < DIM_W'(MAX_WIDTH))  &&
                    (DIM_W'(req.pos_y) < DIM_W'(height_ff)) &&
                    (DIM_W'(req.pos_y) < DIM_W'(MAX_HEIGHT));

   assign req_addr = ADDR_W'(ADDR_W'(req.pos_y) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(req.pos_x);

   // store read on an accepted read or a counted event
   assign ram_rd_en = accept && ((kind == REQ_READ) ||
                                 ((kind == REQ_EVENT) && req.inside_req && in_area));

   assign ram_rd_data = pixel_type'(ram_rd_raw);

   // write port: clearing pass or event write back
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = '0;
      if (state_ff == S_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = cursor_ff;
      end else if ((state_ff == S_READ) && !is_read_ff) begin
         ram_wr_en             = 1'b1;
         ram_wr_data           = ram_rd_data;
         ram_wr_data.touched   = 1'b1;
         ram_wr_data.last_sign = pol_ff;
         if (pol_ff) begin
            ram_wr_data.pos_count = ram_rd_data.pos_count + COUNT_BITS'(1);
         end else begin
            ram_wr_data.neg_count = ram_rd_data.neg_count + COUNT_BITS'(1);
         end
      end
   end

   efa_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_addr),
      .rd_data (ram_rd_raw)
   );

   // pixel latch, out-of-area reads see an untouched zero pixel
   always_comb begin
      pix_in  = ok_ff ? ram_rd_data : '0;
      diff_in = $signed({1'b0, pix_in.pos_count}) - $signed({1'b0, pix_in.neg_count});
      mag_in  = diff_in[COUNT_BITS] ? COUNT_BITS'(-diff_in) : COUNT_BITS'(diff_in);
   end

   // products of the grey value
   assign lo_a       = {mag_ff, 2'b10};
   assign recip_prod = (LO_A_W+RECIP_W)'(lo_a) * (LO_A_W+RECIP_W)'(RECIP_5);
   assign hi_in      = HI_W'(mag_ff) * HI_W'(GREY_WHOLE);
   assign lo_in      = recip_prod[LO_A_W+RECIP_W-1 -: COUNT_BITS];

   // grey value from the registered products
   assign grey_q   = hi_ff + HI_W'(lo_ff);
   assign grey_val = diff_ff[COUNT_BITS] ? GREY_HALF - SV_W'(grey_q)
                                         : GREY_HALF + SV_W'(grey_q);

   // result rendering by display mode
   always_comb begin
      rsp_data_in = '0;
      case (mode_type'(mode_ff))
         MODE_RENDER: begin
            if (!pix_ff.touched) begin
               rsp_data_in.chan_b = SHADE_UNTOUCHED;
               rsp_data_in.chan_g = SHADE_UNTOUCHED;
               rsp_data_in.chan_r = SHADE_UNTOUCHED;
            end else if (pix_ff.last_sign) begin
               rsp_data_in.chan_b = SHADE_FULL;
            end else begin
               rsp_data_in.chan_r = SHADE_FULL;
            end
         end
         MODE_SIGNED: begin
            rsp_data_in.scalar_value = SV_W'(diff_ff);
         end
         MODE_COLOUR: begin
            if (pix_ff.touched) begin
               rsp_data_in.chan_b = CHAN_W'(pix_ff.pos_count);
               rsp_data_in.chan_r = CHAN_W'(pix_ff.neg_count);
            end else begin
               rsp_data_in.chan_b = SHADE_UNIT;
               rsp_data_in.chan_g = SHADE_UNIT;
               rsp_data_in.chan_r = SHADE_UNIT;
            end
         end
         MODE_UNSIGNED: begin
            rsp_data_in.scalar_value = SV_W'(pix_ff.pos_count) + SV_W'(pix_ff.neg_count);
         end
         MODE_GREY: begin
            rsp_data_in.scalar_value = grey_val;
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   assign load_rsp = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cursor_in = cursor_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cursor_in = cursor_ff + ADDR_W'(1);
            if (cursor_ff == ADDR_W'(DEPTH - 1)) begin
               cursor_in = '0;
               state_in  = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (kind == REQ_CLEAR) begin
                  state_in = S_CLEAR;
               end else if (ram_rd_en) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = is_read_ff ? S_MUL : S_IDLE;
         end
         S_MUL: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_COLOUR;
         width_ff     <= DIM_RESET;
         height_ff    <= DIM_RESET;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_MODE:   mode_ff   <= csr_wr_data[MODE_W-1:0];
               CSR_WIDTH:  width_ff  <= csr_wr_data[DIM_REG_W-1:0];
               CSR_HEIGHT: height_ff <= csr_wr_data[DIM_REG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         is_read_ff <= (kind == REQ_READ);
         pol_ff     <= req.polarity;
         ok_ff      <= in_area;
         addr_ff    <= req_addr;
      end
      if (state_ff == S_READ) begin
         pix_ff  <= pix_in;
         diff_ff <= diff_in;
         mag_ff  <= mag_in;
      end
      if (state_ff == S_MUL) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/efa_checker.sv
// ----------------------------------------------------------------------------
// efa_checker
// Port-level checks of the event frame accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module efa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [efa_pkg::KIND_W-1:0]      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [efa_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   import efa_pkg::*;

   logic req_xfer;
   assign req_xfer = req_tvalid && req_tready;

   // reset starts the clearing pass, so no request is taken right after it
   a_reset_clears : assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken right after reset");

   // a read transfer keeps the request side closed while the pixel is fetched
   a_read_busy : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_tuser == REQ_READ)) |=> !req_tready ##1 !req_tready)
      else $error("request taken during a pixel read");

   // a clear transfer starts the clearing pass
   a_clear_busy : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_tuser == REQ_CLEAR)) |=> !req_tready ##1 !req_tready)
      else $error("request taken during the clearing pass");

   // a stalled result holds its value
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // a result leaves only by a transfer or by reset
   a_rsp_drop : assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_tvalid) |-> ($past(rsp_tready) || $past(reset)))
      else $error("result dropped without a transfer");

endmodule

bind event_frame_accumulator efa_checker u_efa_checker (.*);

`default_nettype wire
